// ===== design/dcd_pkg.sv =====
package dcd_pkg;

    // class scores and lanes
    localparam int N_SCORES        = 6;
    localparam int MAX_CLASSES_DEF = 6;
    localparam int SCORE_W         = 10;
    localparam int CLASS_W         = 3;
    localparam int CLASS_IN_W      = 8;

    // box and coordinate widths
    localparam int BOX_W    = 16;
    localparam int CORNER_W = BOX_W + 2;
    localparam int COORD_W  = 12;
    localparam int FRAME_W  = 13;
    localparam int NET_W    = 11;
    localparam int DIV_W    = NET_W + 5;

    // divider: quotient bits below the overflow check, remainder width
    localparam int QBITS       = COORD_W + 1;
    localparam int REM_W       = CORNER_W - 1 + FRAME_W;
    localparam int LANE_STAGES = 2 + QBITS;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = N_SCORES * SCORE_W;

    localparam logic [CFG_IDX_W-1:0] CFG_END_TO_END   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLASSES_USED = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NET_WIDTH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NET_HEIGHT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLDS   = 3'd6;

    // reset values of the registers
    localparam logic [CLASS_W-1:0]    RST_CLASSES_USED = 3'd6;
    localparam logic [NET_W-1:0]      RST_NET_WIDTH    = 11'd640;
    localparam logic [NET_W-1:0]      RST_NET_HEIGHT   = 11'd640;
    localparam logic [FRAME_W-1:0]    RST_FRAME_WIDTH  = 13'd640;
    localparam logic [FRAME_W-1:0]    RST_FRAME_HEIGHT = 13'd480;

    // best class found so far
    typedef struct packed {
        logic [CLASS_W-1:0] cls;
        logic [SCORE_W-1:0] score;
    } t_cand;

    // class and confidence that travel beside the corner lanes
    typedef struct packed {
        logic [CLASS_W-1:0] cls;
        logic [SCORE_W-1:0] conf;
    } t_meta;

    // left operand wins ties, so the first strictly greatest score is kept
    function automatic t_cand merge_cand(input t_cand lo, input t_cand hi);
        t_cand res;
        res = (hi.score > lo.score) ? hi : lo;
        return res;
    endfunction

endpackage

// ===== design/dcd_class_lanes.sv =====
module dcd_class_lanes #(
    parameter int MAX_CLASSES = dcd_pkg::MAX_CLASSES_DEF
) (
    input  logic [dcd_pkg::SCORE_W-1:0] i_scores [dcd_pkg::N_SCORES],
    input  logic [dcd_pkg::CLASS_W-1:0] i_classes_used,
    output dcd_pkg::t_cand              o_best
);

    dcd_pkg::t_cand lane [dcd_pkg::N_SCORES];
    dcd_pkg::t_cand m01, m23, m45, m0123;

    // one lane per class: score masked off when the class is not in use
    for (genvar k = 0; k < dcd_pkg::N_SCORES; k++) begin : g_lane
        localparam logic [dcd_pkg::CLASS_W-1:0] K = dcd_pkg::CLASS_W'(k);
        logic in_use;
        assign in_use = (k < MAX_CLASSES) && (K < i_classes_used);
        assign lane[k].cls   = K;
        assign lane[k].score = in_use ? i_scores[k] : '0;
    end

    // merge tree, lower classes on the left
    assign m01    = dcd_pkg::merge_cand(lane[0], lane[1]);
    assign m23    = dcd_pkg::merge_cand(lane[2], lane[3]);
    assign m45    = dcd_pkg::merge_cand(lane[4], lane[5]);
    assign m0123  = dcd_pkg::merge_cand(m01, m23);
    assign o_best = dcd_pkg::merge_cand(m0123, m45);

endmodule

// ===== design/dcd_corner_lane.sv =====
module dcd_corner_lane (
    input  logic                                i_clk,
    input  logic [dcd_pkg::LANE_STAGES-1:0]     i_en,
    input  logic signed [dcd_pkg::CORNER_W-1:0] i_corner,
    input  logic [dcd_pkg::FRAME_W-1:0]         i_frame,
    input  logic [dcd_pkg::DIV_W-1:0]           i_div,
    output logic [dcd_pkg::COORD_W-1:0]         o_coord
);

    localparam int REM_W = dcd_pkg::REM_W;
    localparam int QBITS = dcd_pkg::QBITS;
    localparam int LAST  = dcd_pkg::LANE_STAGES - 1;

    typedef struct packed {
        logic             nonpos;
        logic             ovf;
        logic [REM_W-1:0] rem;
        logic [QBITS-1:0] q;
    } t_div_stage;

    t_div_stage r_stg [dcd_pkg::LANE_STAGES];

    logic [REM_W-1:0]   div_ext;
    logic [REM_W-1:0]   n_prod;
    logic               n_nonpos;
    logic [dcd_pkg::FRAME_W-1:0] hi_full;
    logic [dcd_pkg::COORD_W-1:0] hi;
    logic               over;

    assign div_ext = REM_W'(i_div);

    // multiply: only a positive corner can land inside the frame
    assign n_nonpos = i_corner[dcd_pkg::CORNER_W-1] || (i_corner == '0);
    assign n_prod   = i_corner[dcd_pkg::CORNER_W-2:0] * i_frame;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_stg[0].nonpos <= n_nonpos;
            r_stg[0].ovf    <= 1'b0;
            r_stg[0].rem    <= n_prod;
            r_stg[0].q      <= '0;
        end
    end

    // quotient beyond the bits below always clamps
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_stg[1].nonpos <= r_stg[0].nonpos;
            r_stg[1].ovf    <= (r_stg[0].rem >= (div_ext << QBITS));
            r_stg[1].rem    <= r_stg[0].rem;
            r_stg[1].q      <= '0;
        end
    end

    // restoring division, one quotient bit per stage, msb first
    for (genvar j = 0; j < QBITS; j++) begin : g_div
        localparam int SH = QBITS - 1 - j;
        logic [REM_W-1:0] sub;
        logic             take;
        assign sub  = div_ext << SH;
        assign take = (r_stg[j+1].rem >= sub);
        always_ff @(posedge i_clk) begin
            if (i_en[j+2]) begin
                r_stg[j+2].nonpos <= r_stg[j+1].nonpos;
                r_stg[j+2].ovf    <= r_stg[j+1].ovf;
                r_stg[j+2].rem    <= take ? (r_stg[j+1].rem - sub) : r_stg[j+1].rem;
                r_stg[j+2].q      <= r_stg[j+1].q | (QBITS'(take) << SH);
            end
        end
    end

    // clamp to the frame
    assign hi_full = i_frame - dcd_pkg::FRAME_W'(1);
    assign hi      = hi_full[dcd_pkg::COORD_W-1:0];
    assign over    = r_stg[LAST].ovf || (r_stg[LAST].q > {1'b0, hi});
    assign o_coord = r_stg[LAST].nonpos ? '0 :
                     over               ? hi : r_stg[LAST].q[dcd_pkg::COORD_W-1:0];

endmodule

// ===== design/detection_candidate_decode_top.sv =====
// Detection candidate decode. One candidate word is taken per clock while
// o_in_ready is high; a kept detection passes the decode stage (loaded by
// the accepting edge), then fifteen scaling stages and one output register,
// and dropped candidates leave no word. The scaling stages are the four corner
// lanes, each a 13-stage restoring divider behind a 17x13 multiplier that maps
// network pixels to frame pixels.
// Bubbles close up, so input keeps flowing while a result waits on the output
// until the pipe fills. Configuration may only be written with the pipe empty.
module detection_candidate_decode_top #(
    parameter int MAX_CLASSES = dcd_pkg::MAX_CLASSES_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [dcd_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [dcd_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    // candidate in
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [dcd_pkg::BOX_W-1:0]      i_box_a,
    input  logic signed [dcd_pkg::BOX_W-1:0]      i_box_b,
    input  logic signed [dcd_pkg::BOX_W-1:0]      i_box_c,
    input  logic signed [dcd_pkg::BOX_W-1:0]      i_box_d,
    input  logic signed [dcd_pkg::CLASS_IN_W-1:0] i_class_in,
    input  logic [dcd_pkg::SCORE_W-1:0]           i_score_0,
    input  logic [dcd_pkg::SCORE_W-1:0]           i_score_1,
    input  logic [dcd_pkg::SCORE_W-1:0]           i_score_2,
    input  logic [dcd_pkg::SCORE_W-1:0]           i_score_3,
    input  logic [dcd_pkg::SCORE_W-1:0]           i_score_4,
    input  logic [dcd_pkg::SCORE_W-1:0]           i_score_5,
    // detection out
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [dcd_pkg::CLASS_W-1:0]           o_label,
    output logic [dcd_pkg::SCORE_W-1:0]           o_confidence,
    output logic [dcd_pkg::COORD_W-1:0]           o_left_x,
    output logic [dcd_pkg::COORD_W-1:0]           o_top_y,
    output logic [dcd_pkg::COORD_W-1:0]           o_right_x,
    output logic [dcd_pkg::COORD_W-1:0]           o_bottom_y
);

    localparam int L        = dcd_pkg::LANE_STAGES;
    localparam int CW       = dcd_pkg::CORNER_W;
    localparam int SW       = dcd_pkg::SCORE_W;
    localparam int FW       = dcd_pkg::FRAME_W;
    localparam int NW       = dcd_pkg::NET_W;

    // configuration registers
    logic                          r_end_to_end_mode;
    logic [dcd_pkg::CLASS_W-1:0]   r_classes_used;
    logic [NW-1:0]                 r_net_width;
    logic [NW-1:0]                 r_net_height;
    logic [FW-1:0]                 r_frame_width;
    logic [FW-1:0]                 r_frame_height;
    logic [dcd_pkg::CFG_DATA_W-1:0] r_class_thresholds;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_to_end_mode  <= 1'b0;
            r_classes_used     <= dcd_pkg::RST_CLASSES_USED;
            r_net_width        <= dcd_pkg::RST_NET_WIDTH;
            r_net_height       <= dcd_pkg::RST_NET_HEIGHT;
            r_frame_width      <= dcd_pkg::RST_FRAME_WIDTH;
            r_frame_height     <= dcd_pkg::RST_FRAME_HEIGHT;
            r_class_thresholds <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                dcd_pkg::CFG_END_TO_END:   r_end_to_end_mode  <= i_cfg_data[0];
                dcd_pkg::CFG_CLASSES_USED: r_classes_used     <= i_cfg_data[dcd_pkg::CLASS_W-1:0];
                dcd_pkg::CFG_NET_WIDTH:    r_net_width        <= i_cfg_data[NW-1:0];
                dcd_pkg::CFG_NET_HEIGHT:   r_net_height       <= i_cfg_data[NW-1:0];
                dcd_pkg::CFG_FRAME_WIDTH:  r_frame_width      <= i_cfg_data[FW-1:0];
                dcd_pkg::CFG_FRAME_HEIGHT: r_frame_height     <= i_cfg_data[FW-1:0];
                dcd_pkg::CFG_THRESHOLDS:   r_class_thresholds <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective settings: saturated class count, nonzero net, bounded frame
    logic [dcd_pkg::CLASS_W-1:0] ncls;
    logic [NW-1:0]               net_w_eff, net_h_eff;
    logic [FW-1:0]               frame_w_eff, frame_h_eff;
    logic [dcd_pkg::DIV_W-1:0]   div_w, div_h;

    function automatic logic [FW-1:0] frame_eff(input logic [FW-1:0] f);
        logic [FW-1:0] res;
        if (f == '0) begin
            res = FW'(1);
        end else if (f[FW-1] && (f[FW-2:0] != '0)) begin
            res = {1'b1, {(FW-1){1'b0}}};
        end else begin
            res = f;
        end
        return res;
    endfunction

    assign ncls        = (r_classes_used > dcd_pkg::CLASS_W'(MAX_CLASSES)) ?
                         dcd_pkg::CLASS_W'(MAX_CLASSES) : r_classes_used;
    assign net_w_eff   = (r_net_width == '0)  ? NW'(1) : r_net_width;
    assign net_h_eff   = (r_net_height == '0) ? NW'(1) : r_net_height;
    assign frame_w_eff = frame_eff(r_frame_width);
    assign frame_h_eff = frame_eff(r_frame_height);
    assign div_w       = {net_w_eff, 5'b0};
    assign div_h       = {net_h_eff, 5'b0};

    // class lanes pick the raw-mode class
    logic [SW-1:0]  scores [dcd_pkg::N_SCORES];
    dcd_pkg::t_cand best;

    assign scores[0] = i_score_0;
    assign scores[1] = i_score_1;
    assign scores[2] = i_score_2;
    assign scores[3] = i_score_3;
    assign scores[4] = i_score_4;
    assign scores[5] = i_score_5;

    dcd_class_lanes #(
        .MAX_CLASSES(MAX_CLASSES)
    ) u_class_lanes (
        .i_scores      (scores),
        .i_classes_used(ncls),
        .o_best        (best)
    );

    // decode: class, confidence, threshold and corners in 1/32 pixel
    logic signed [CW-1:0] a2, b2, c2, d2, c1, d1;
    logic signed [CW-1:0] n_left, n_top, n_right, n_bottom;
    logic                 n_found;
    logic                 n_keep;
    dcd_pkg::t_meta       n_meta;
    logic [SW-1:0]        thr;
    logic                 id_ok;

    assign a2 = $signed({i_box_a[dcd_pkg::BOX_W-1], i_box_a, 1'b0});
    assign b2 = $signed({i_box_b[dcd_pkg::BOX_W-1], i_box_b, 1'b0});
    assign c2 = $signed({i_box_c[dcd_pkg::BOX_W-1], i_box_c, 1'b0});
    assign d2 = $signed({i_box_d[dcd_pkg::BOX_W-1], i_box_d, 1'b0});
    assign c1 = $signed({{2{i_box_c[dcd_pkg::BOX_W-1]}}, i_box_c});
    assign d1 = $signed({{2{i_box_d[dcd_pkg::BOX_W-1]}}, i_box_d});

    assign id_ok = !i_class_in[dcd_pkg::CLASS_IN_W-1] &&
                   (i_class_in[dcd_pkg::CLASS_IN_W-2:0] <
                    (dcd_pkg::CLASS_IN_W-1)'(ncls));

    always_comb begin
        if (r_end_to_end_mode) begin
            n_found     = id_ok;
            n_meta.cls  = i_class_in[dcd_pkg::CLASS_W-1:0];
            n_meta.conf = i_score_0;
            n_left      = a2;
            n_top       = b2;
            n_right     = c2;
            n_bottom    = d2;
        end else begin
            n_found     = (best.score != '0);
            n_meta.cls  = best.cls;
            n_meta.conf = best.score;
            n_left      = a2 - c1;
            n_right     = a2 + c1;
            n_top       = b2 - d1;
            n_bottom    = b2 + d1;
        end
    end

    // threshold of the chosen class
    always_comb begin
        case (n_meta.cls)
            3'd0:    thr = r_class_thresholds[0*SW +: SW];
            3'd1:    thr = r_class_thresholds[1*SW +: SW];
            3'd2:    thr = r_class_thresholds[2*SW +: SW];
            3'd3:    thr = r_class_thresholds[3*SW +: SW];
            3'd4:    thr = r_class_thresholds[4*SW +: SW];
            3'd5:    thr = r_class_thresholds[5*SW +: SW];
            default: thr = '0;
        endcase
    end

    assign n_keep = n_found && (n_meta.conf >= thr);

    // pipeline valid bits and advance chain, bubbles collapse
    logic [L:0]             r_v;
    logic [L:0]             adv;
    logic                   out_adv;
    dcd_pkg::t_meta         r_meta [L+1];
    logic signed [CW-1:0]   r_left, r_top, r_right, r_bottom;

    assign out_adv = !o_out_valid || i_out_ready;

    always_comb begin
        adv[L] = !r_v[L] || out_adv;
        for (int k = L - 1; k >= 0; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
    end

    assign o_in_ready = adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[0]) begin
                r_v[0] <= i_in_valid && n_keep;
            end
            for (int k = 1; k <= L; k++) begin
                if (adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // decode stage and side band payload
    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_meta[0] <= n_meta;
            r_left    <= n_left;
            r_top     <= n_top;
            r_right   <= n_right;
            r_bottom  <= n_bottom;
        end
        for (int k = 1; k <= L; k++) begin
            if (adv[k]) begin
                r_meta[k] <= r_meta[k-1];
            end
        end
    end

    // four corner lanes
    logic [dcd_pkg::COORD_W-1:0] x1, y1, x2, y2;

    dcd_corner_lane u_lane_left (
        .i_clk(i_clk), .i_en(adv[L:1]), .i_corner(r_left),
        .i_frame(frame_w_eff), .i_div(div_w), .o_coord(x1)
    );

    dcd_corner_lane u_lane_top (
        .i_clk(i_clk), .i_en(adv[L:1]), .i_corner(r_top),
        .i_frame(frame_h_eff), .i_div(div_h), .o_coord(y1)
    );

    dcd_corner_lane u_lane_right (
        .i_clk(i_clk), .i_en(adv[L:1]), .i_corner(r_right),
        .i_frame(frame_w_eff), .i_div(div_w), .o_coord(x2)
    );

    dcd_corner_lane u_lane_bottom (
        .i_clk(i_clk), .i_en(adv[L:1]), .i_corner(r_bottom),
        .i_frame(frame_h_eff), .i_div(div_h), .o_coord(y2)
    );

    // merge: drop empty boxes, load output register
    logic box_ok;
    assign box_ok = (x2 > x1) && (y2 > y1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (out_adv) begin
            o_out_valid <= r_v[L] && box_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && r_v[L]) begin
            o_label      <= r_meta[L].cls;
            o_confidence <= r_meta[L].conf;
            o_left_x     <= x1;
            o_top_y      <= y1;
            o_right_x    <= x2;
            o_bottom_y   <= y2;
        end
    end

endmodule

// ===== tb/detection_candidate_decode_top_tb.sv =====
module detection_candidate_decode_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_DRAIN  = 40;    // comfortably longer than the pipe takes to empty
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 5000;

    // one candidate word and one detection word
    typedef struct {
        logic signed [dcd_pkg::BOX_W-1:0]                   box_a;
        logic signed [dcd_pkg::BOX_W-1:0]                   box_b;
        logic signed [dcd_pkg::BOX_W-1:0]                   box_c;
        logic signed [dcd_pkg::BOX_W-1:0]                   box_d;
        logic signed [dcd_pkg::CLASS_IN_W-1:0]              class_in;
        logic [dcd_pkg::N_SCORES-1:0][dcd_pkg::SCORE_W-1:0] score;
    } t_candidate;

    typedef struct {
        logic [dcd_pkg::CLASS_W-1:0] label;
        logic [dcd_pkg::SCORE_W-1:0] confidence;
        logic [dcd_pkg::COORD_W-1:0] left_x;
        logic [dcd_pkg::COORD_W-1:0] top_y;
        logic [dcd_pkg::COORD_W-1:0] right_x;
        logic [dcd_pkg::COORD_W-1:0] bottom_y;
    } t_detection;

    // predicts kept detections and checks them in order
    class t_scoreboard;
        bit                             end_to_end;
        logic [dcd_pkg::CLASS_W-1:0]    classes_used;
        logic [dcd_pkg::NET_W-1:0]      net_width;
        logic [dcd_pkg::NET_W-1:0]      net_height;
        logic [dcd_pkg::FRAME_W-1:0]    frame_width;
        logic [dcd_pkg::FRAME_W-1:0]    frame_height;
        logic [dcd_pkg::CFG_DATA_W-1:0] thresholds;
        t_detection                     awaited[$];
        int                             mismatches;

        function new();
            end_to_end   = 1'b0;
            classes_used = dcd_pkg::RST_CLASSES_USED;
            net_width    = dcd_pkg::RST_NET_WIDTH;
            net_height   = dcd_pkg::RST_NET_HEIGHT;
            frame_width  = dcd_pkg::RST_FRAME_WIDTH;
            frame_height = dcd_pkg::RST_FRAME_HEIGHT;
            thresholds   = '0;
            mismatches   = 0;
        endfunction

        function void set_register(logic [dcd_pkg::CFG_IDX_W-1:0] idx,
                                   logic [dcd_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                dcd_pkg::CFG_END_TO_END:   end_to_end   = data[0];
                dcd_pkg::CFG_CLASSES_USED: classes_used = data[dcd_pkg::CLASS_W-1:0];
                dcd_pkg::CFG_NET_WIDTH:    net_width    = data[dcd_pkg::NET_W-1:0];
                dcd_pkg::CFG_NET_HEIGHT:   net_height   = data[dcd_pkg::NET_W-1:0];
                dcd_pkg::CFG_FRAME_WIDTH:  frame_width  = data[dcd_pkg::FRAME_W-1:0];
                dcd_pkg::CFG_FRAME_HEIGHT: frame_height = data[dcd_pkg::FRAME_W-1:0];
                dcd_pkg::CFG_THRESHOLDS:   thresholds   = data;
                default: ;
            endcase
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // zero net size acts as one
        function longint net_eff(logic [dcd_pkg::NET_W-1:0] n);
            return (n == 0) ? 1 : longint'(n);
        endfunction

        // zero frame acts as one, large frames saturate
        function longint frame_eff(logic [dcd_pkg::FRAME_W-1:0] f);
            if (f == 0) return 1;
            if (f > 4096) return 4096;
            return longint'(f);
        endfunction

        // corner in 1/32 network pixel to clamped frame pixel
        function longint to_frame(longint corner, longint net, longint frame);
            longint q;
            q = (corner * frame) / (32 * net);
            if (q < 0) q = 0;
            if (q > frame - 1) q = frame - 1;
            return q;
        endfunction

        function void note_candidate(t_candidate cand);
            longint     ncls, nw, nh, fw, fh;
            longint     a, b, c, d, cls, conf, thr;
            longint     x_lo, y_lo, x_hi, y_hi;
            int         k;
            t_detection det;
            ncls = (classes_used > dcd_pkg::MAX_CLASSES_DEF) ?
                   dcd_pkg::MAX_CLASSES_DEF : longint'(classes_used);
            nw   = net_eff(net_width);
            nh   = net_eff(net_height);
            fw   = frame_eff(frame_width);
            fh   = frame_eff(frame_height);
            a    = cand.box_a;
            b    = cand.box_b;
            c    = cand.box_c;
            d    = cand.box_d;
            cls  = -1;
            conf = 0;
            if (end_to_end) begin
                cls  = cand.class_in;
                conf = cand.score[0];
                if (cls < 0 || cls >= ncls) return;
                x_lo = 2 * a;
                y_lo = 2 * b;
                x_hi = 2 * c;
                y_hi = 2 * d;
            end else begin
                // first strictly greatest nonzero score wins
                for (k = 0; k < ncls; k++) begin
                    if (longint'(cand.score[k]) > conf) begin
                        conf = cand.score[k];
                        cls  = k;
                    end
                end
                if (cls < 0) return;
                x_lo = 2 * a - c;
                x_hi = 2 * a + c;
                y_lo = 2 * b - d;
                y_hi = 2 * b + d;
            end
            thr = (thresholds >> (10 * cls)) & 60'h3FF;
            if (conf < thr) return;
            x_lo = to_frame(x_lo, nw, fw);
            y_lo = to_frame(y_lo, nh, fh);
            x_hi = to_frame(x_hi, nw, fw);
            y_hi = to_frame(y_hi, nh, fh);
            if (x_hi <= x_lo || y_hi <= y_lo) return;
            det.label      = dcd_pkg::CLASS_W'(cls);
            det.confidence = dcd_pkg::SCORE_W'(conf);
            det.left_x     = dcd_pkg::COORD_W'(x_lo);
            det.top_y      = dcd_pkg::COORD_W'(y_lo);
            det.right_x    = dcd_pkg::COORD_W'(x_hi);
            det.bottom_y   = dcd_pkg::COORD_W'(y_hi);
            awaited.insert(awaited.size(), det);
        endfunction

        function void compare_field(string name, logic [dcd_pkg::COORD_W-1:0] want,
                                    logic [dcd_pkg::COORD_W-1:0] got);
            if (got !== want) begin
                mismatches++;
                $display("time %0t: %s expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void check_detection(t_detection got);
            t_detection want;
            if (awaited.size() == 0) begin
                mismatches++;
                $display("time %0t: unexpected detection, expected none, got class %0d",
                         $time, got.label);
                return;
            end
            want = awaited.pop_front();
            compare_field("label", dcd_pkg::COORD_W'(want.label),
                          dcd_pkg::COORD_W'(got.label));
            compare_field("confidence", dcd_pkg::COORD_W'(want.confidence),
                          dcd_pkg::COORD_W'(got.confidence));
            compare_field("left_x", want.left_x, got.left_x);
            compare_field("top_y", want.top_y, got.top_y);
            compare_field("right_x", want.right_x, got.right_x);
            compare_field("bottom_y", want.bottom_y, got.bottom_y);
        endfunction
    endclass

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [dcd_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [dcd_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_ready;
    logic                           o_out_valid;
    logic                           i_out_ready = 1'b0;
    logic [dcd_pkg::CLASS_W-1:0]    o_label;
    logic [dcd_pkg::SCORE_W-1:0]    o_confidence;
    logic [dcd_pkg::COORD_W-1:0]    o_left_x;
    logic [dcd_pkg::COORD_W-1:0]    o_top_y;
    logic [dcd_pkg::COORD_W-1:0]    o_right_x;
    logic [dcd_pkg::COORD_W-1:0]    o_bottom_y;

    t_candidate            offered;
    t_scoreboard           sb;
    bit                    steady_in = 1'b0;
    bit                    steady_out = 1'b0;
    int                    hold_serial = 0;
    int                    quiet_cycles = 0;

    detection_candidate_decode_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_box_a      (offered.box_a),
        .i_box_b      (offered.box_b),
        .i_box_c      (offered.box_c),
        .i_box_d      (offered.box_d),
        .i_class_in   (offered.class_in),
        .i_score_0    (offered.score[0]),
        .i_score_1    (offered.score[1]),
        .i_score_2    (offered.score[2]),
        .i_score_3    (offered.score[3]),
        .i_score_4    (offered.score[4]),
        .i_score_5    (offered.score[5]),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_label      (o_label),
        .o_confidence (o_confidence),
        .o_left_x     (o_left_x),
        .o_top_y      (o_top_y),
        .o_right_x    (o_right_x),
        .o_bottom_y   (o_bottom_y)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // note accepted candidates, check accepted detections
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready)
            sb.note_candidate(offered);
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_detection(t_detection'{o_label, o_confidence, o_left_x,
                                            o_top_y, o_right_x, o_bottom_y});
    end

    // receiver: random stalls, long hold-off on request
    always @(posedge i_clk) begin : receiver
        int hold_seen;
        int hold_left;
        if (hold_serial != hold_seen) begin
            hold_seen = hold_serial;
            hold_left = HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (steady_out) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= 32);
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("detection_candidate_decode_top_tb: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_candidate make_candidate(int a, int b, int c, int d, int cls,
                                                  int s0, int s1, int s2, int s3,
                                                  int s4, int s5);
        t_candidate cand;
        cand.box_a    = dcd_pkg::BOX_W'(a);
        cand.box_b    = dcd_pkg::BOX_W'(b);
        cand.box_c    = dcd_pkg::BOX_W'(c);
        cand.box_d    = dcd_pkg::BOX_W'(d);
        cand.class_in = dcd_pkg::CLASS_IN_W'(cls);
        cand.score[0] = dcd_pkg::SCORE_W'(s0);
        cand.score[1] = dcd_pkg::SCORE_W'(s1);
        cand.score[2] = dcd_pkg::SCORE_W'(s2);
        cand.score[3] = dcd_pkg::SCORE_W'(s3);
        cand.score[4] = dcd_pkg::SCORE_W'(s4);
        cand.score[5] = dcd_pkg::SCORE_W'(s5);
        return cand;
    endfunction

    // mostly boxes that land in the frame, some pure noise
    function automatic t_candidate random_candidate();
        t_candidate cand;
        int         span_x, span_y, lo_x, lo_y, hi_x, hi_y, k;
        span_x = int'(sb.net_eff(sb.net_width)) * 16;
        span_y = int'(sb.net_eff(sb.net_height)) * 16;
        for (k = 0; k < dcd_pkg::N_SCORES; k++) begin
            case ($urandom_range(9))
                0, 1, 2: cand.score[k] = '0;
                3:       cand.score[k] = '1;
                4:       cand.score[k] = (k > 0) ? cand.score[k-1] :
                                         dcd_pkg::SCORE_W'($urandom);
                default: cand.score[k] = dcd_pkg::SCORE_W'($urandom);
            endcase
        end
        if (sb.end_to_end && $urandom_range(99) < 85)
            cand.class_in = dcd_pkg::CLASS_IN_W'($urandom_range(5));
        else
            cand.class_in = dcd_pkg::CLASS_IN_W'($urandom);
        if ($urandom_range(99) < 10) begin
            cand.box_a = dcd_pkg::BOX_W'($urandom);
            cand.box_b = dcd_pkg::BOX_W'($urandom);
            cand.box_c = dcd_pkg::BOX_W'($urandom);
            cand.box_d = dcd_pkg::BOX_W'($urandom);
            return cand;
        end
        lo_x = int'($urandom_range(span_x));
        lo_y = int'($urandom_range(span_y));
        if ($urandom_range(7) == 0) lo_x -= int'($urandom_range(span_x / 4));
        if ($urandom_range(7) == 0) lo_y -= int'($urandom_range(span_y / 4));
        hi_x = int'($urandom_range(span_x));
        hi_y = int'($urandom_range(span_y));
        if (sb.end_to_end) begin
            // corners: right and bottom past the top-left one
            hi_x = (lo_x + hi_x > 32767) ? 32767 : lo_x + hi_x;
            hi_y = (lo_y + hi_y > 32767) ? 32767 : lo_y + hi_y;
            if ($urandom_range(19) == 0) hi_x = lo_x;
        end else if ($urandom_range(19) == 0) begin
            // center and size: sometimes a negative size
            hi_x = -hi_x;
        end
        cand.box_a = dcd_pkg::BOX_W'(lo_x);
        cand.box_b = dcd_pkg::BOX_W'(lo_y);
        cand.box_c = dcd_pkg::BOX_W'(hi_x);
        cand.box_d = dcd_pkg::BOX_W'(hi_y);
        return cand;
    endfunction

    // offer one word, with random gaps in front, until it is taken
    task automatic send_candidate(t_candidate cand);
        while (!steady_in && $urandom_range(99) < 32) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        offered    <= cand;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic feed_random(int count);
        repeat (count) send_candidate(random_candidate());
    endtask

    // stop offering and wait for every awaited detection
    task automatic drain_detections();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic write_register(logic [dcd_pkg::CFG_IDX_W-1:0] idx,
                                  logic [dcd_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_register(idx, data);
    endtask

    // registers are only touched with the pipe empty
    task automatic configure(bit e2e, int cnt, int nw, int nh, int fw, int fh,
                             logic [dcd_pkg::CFG_DATA_W-1:0] thr);
        drain_detections();
        repeat (PIPE_DRAIN) @(posedge i_clk);
        write_register(dcd_pkg::CFG_END_TO_END, dcd_pkg::CFG_DATA_W'(e2e));
        write_register(dcd_pkg::CFG_CLASSES_USED, dcd_pkg::CFG_DATA_W'(cnt));
        write_register(dcd_pkg::CFG_NET_WIDTH, dcd_pkg::CFG_DATA_W'(nw));
        write_register(dcd_pkg::CFG_NET_HEIGHT, dcd_pkg::CFG_DATA_W'(nh));
        write_register(dcd_pkg::CFG_FRAME_WIDTH, dcd_pkg::CFG_DATA_W'(fw));
        write_register(dcd_pkg::CFG_FRAME_HEIGHT, dcd_pkg::CFG_DATA_W'(fh));
        write_register(dcd_pkg::CFG_THRESHOLDS, thr);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        sb      = new();
        offered = make_candidate(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings, raw mode: class pick and box corner cases
        send_candidate(make_candidate(5120, 5120, 1600, 1600, 0, 0, 0, 0, 0, 0, 0));
        send_candidate(make_candidate(5120, 5120, 1600, 1600, 0, 0, 500, 0, 500, 0, 0));
        send_candidate(make_candidate(4000, 3000, 800, 2400, 0,
                                      1022, 1022, 1022, 1022, 1022, 1023));
        send_candidate(make_candidate(4000, 3000, 800, 2400, 0, 1, 0, 0, 0, 0, 0));
        send_candidate(make_candidate(32767, 32767, 32767, 32767, 0, 9, 9, 9, 9, 9, 9));
        send_candidate(make_candidate(-32768, -32768, -32768, -32768, 0, 7, 0, 0, 0, 0, 0));
        send_candidate(make_candidate(32767, 100, -32768, 1600, 0, 7, 0, 0, 0, 0, 0));
        send_candidate(make_candidate(5120, 5120, 0, 1600, 0, 0, 0, 300, 0, 0, 0));
        send_candidate(make_candidate(5120, 5120, -1600, 1600, 0, 0, 0, 300, 0, 0, 0));
        send_candidate(make_candidate(5120, 5120, 32767, 32767, -128, 0, 0, 0, 0, 600, 0));
        send_candidate(make_candidate(5120, 5120, 1600, 1600, 127, 0, 0, 0, 0, 0, 1023));

        // wide frame, no idling for the first half, then a full drain
        configure(1'b0, 6, 640, 640, 1920, 1080,
                  {10'd200, 10'd100, 10'd400, 10'd0, 10'd700, 10'd50});
        steady_in  = 1'b1;
        steady_out = 1'b1;
        feed_random(100);
        steady_in  = 1'b0;
        steady_out = 1'b0;
        drain_detections();
        feed_random(100);

        // end-to-end corners: class id range and threshold edges
        configure(1'b1, 6, 640, 640, 640, 480,
                  {10'd50, 10'd900, 10'd0, 10'd1023, 10'd300, 10'd0});
        send_candidate(make_candidate(1600, 1600, 4800, 4000, -1, 500, 0, 0, 0, 0, 0));
        send_candidate(make_candidate(1600, 1600, 4800, 4000, -128, 500, 0, 0, 0, 0, 0));
        send_candidate(make_candidate(1600, 1600, 4800, 4000, 6, 500, 0, 0, 0, 0, 0));
        send_candidate(make_candidate(1600, 1600, 4800, 4000, 127, 500, 0, 0, 0, 0, 0));
        send_candidate(make_candidate(1600, 1600, 4800, 4000, 0, 0, 0, 0, 0, 0, 0));
        send_candidate(make_candidate(1600, 1600, 4800, 4000, 1, 299, 0, 0, 0, 0, 0));
        send_candidate(make_candidate(1600, 1600, 4800, 4000, 1, 300, 0, 0, 0, 0, 0));
        send_candidate(make_candidate(1600, 1600, 4800, 4000, 2, 1023, 0, 0, 0, 0, 0));
        send_candidate(make_candidate(1600, 1600, 1600, 4000, 5, 1023, 0, 0, 0, 0, 0));
        send_candidate(make_candidate(-32768, -32768, 32767, 32767, 3, 400, 0, 0, 0, 0, 0));
        send_candidate(make_candidate(100, 200, 9000, 7000, 4, 900, 1023, 1023, 1, 2, 3));
        feed_random(200);

        // zero net width acts as one, single class
        configure(1'b0, 1, 0, 1, 4096, 4095, '0);
        feed_random(150);

        // no class in use, degenerate frame: everything dropped
        configure(1'b1, 0, 0, 0, 1, 0, '0);
        feed_random(40);

        // class count saturates, largest sizes, top thresholds
        configure(1'b0, 7, 2047, 2047, 4096, 4096, '1);
        feed_random(200);

        // frame sizes beyond the limit saturate
        configure(1'b1, 3, 2047, 2047, 8191, 5000,
                  {10'd0, 10'd0, 10'd0, 10'd600, 10'd0, 10'd100});
        feed_random(200);

        // long receiver hold-off while the sender keeps pushing
        configure(1'b0, 4, 320, 256, 4096, 3000,
                  {10'd0, 10'd0, 10'd250, 10'd500, 10'd10, 10'd300});
        feed_random(80);
        steady_in = 1'b1;
        hold_serial++;
        feed_random(80);
        steady_in = 1'b0;
        feed_random(90);

        // fully random settings
        repeat (4) begin
            configure(bit'($urandom_range(1)), $urandom_range(7), $urandom_range(2047),
                      $urandom_range(2047), $urandom_range(8191), $urandom_range(8191),
                      dcd_pkg::CFG_DATA_W'({$urandom, $urandom}));
            feed_random(60);
        end

        drain_detections();
        repeat (PIPE_DRAIN) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("detection_candidate_decode_top_tb: PASS");
        end else begin
            $display("detection_candidate_decode_top_tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/dcd_pkg.sv
design/dcd_class_lanes.sv
design/dcd_corner_lane.sv
design/detection_candidate_decode_top.sv
tb/detection_candidate_decode_top_tb.sv
